// ----- rtl/trs_pkg.sv -----
// Shared types, constants and arithmetic helpers of the translate-scale-rotate
// model matrix block. No dependencies.
package trs_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } out_item_t;

  // Unsigned Q2.30 one and two pi scaled for the angle conversion.
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [46:0] TWO_PI_Q30 = 47'd6746518852;

  // Reciprocals floor(2^36 / d) for the Taylor divisions.
  localparam int unsigned RecipShift = 36;
  localparam logic [63:0] R42 = 64'((64'd1 << RecipShift) / 64'd42);
  localparam logic [63:0] R56 = 64'((64'd1 << RecipShift) / 64'd56);
  localparam logic [63:0] R20 = 64'((64'd1 << RecipShift) / 64'd20);
  localparam logic [63:0] R30 = 64'((64'd1 << RecipShift) / 64'd30);
  localparam logic [63:0] R6  = 64'((64'd1 << RecipShift) / 64'd6);
  localparam logic [63:0] R12 = 64'((64'd1 << RecipShift) / 64'd12);

  // (a * b) >> 30 for a below one and b up to one.
  function automatic logic [29:0] mul30(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] p;
    p = 61'(a) * 61'(b);
    return p[59:30];
  endfunction

  // Quotient v / d from the reciprocal product, which is low by at most one.
  function automatic logic [29:0] div_fix(input logic [29:0] v, input logic [63:0] prod,
                                          input logic [5:0] d);
    logic [29:0] q0;
    logic [31:0] rem;
    q0  = {2'b00, prod[63:36]};
    rem = 32'(v) - 32'(q0) * 32'(d);
    if (rem >= 32'(d)) begin
      q0 = q0 + 30'd1;
    end
    return q0;
  endfunction

  // Q1.15 product rounded half toward plus infinity.
  function automatic logic signed [16:0] fmul(input logic signed [16:0] a,
                                              input logic signed [16:0] b);
    logic signed [34:0] p;
    p = 35'(a) * 35'(b);
    p = p + 35'sd16384;
    return p[31:15];
  endfunction

  // Saturate a sum to plus or minus one.
  function automatic logic signed [16:0] clamp1(input logic signed [17:0] v);
    if (v > 18'sd32768) begin
      return 17'sd32768;
    end else if (v < -18'sd32768) begin
      return -17'sd32768;
    end
    return v[16:0];
  endfunction

  // Q1.15 times Q8.8, rounded to Q16.16.
  function automatic logic signed [31:0] scale_out(input logic signed [16:0] r,
                                                   input logic signed [15:0] s);
    logic signed [33:0] p;
    p = 34'(r) * 34'(s);
    p = p + 34'sd64;
    return 32'(p >>> 7);
  endfunction

endpackage

// ----- rtl/trs_in_if.sv -----
// Input channel: valid/ready handshake carrying one transform request.
// Depends on trs_pkg.
interface trs_in_if;
  logic             valid;
  logic             ready;
  trs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/trs_out_if.sv -----
// Result channel: valid/ready handshake carrying one model matrix.
// Depends on trs_pkg.
interface trs_out_if;
  logic              valid;
  logic              ready;
  trs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/trs_sincos.sv -----
// Twelve-stage pipelined sine and cosine of a binary angle in Q1.15, from
// octant reduction and Taylor polynomials. Depends on trs_pkg.
module trs_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [16:0] sin_o,
  output logic signed [16:0] cos_o
);
  import trs_pkg::*;

  logic [29:0] x_r  [1:10];
  logic [29:0] x2_r [2:10];
  logic [1:0]  qd_r [1:11];
  logic        sw_r [1:11];

  logic [63:0] prs3_r, prc3_r, prs6_r, prc6_r, prs9_r, prc9_r;
  logic [30:0] ps4_r, pc4_r, ps7_r, pc7_r, ps10_r, pc10_r;
  logic [29:0] ms5_r, mc5_r, ms6_r, mc6_r, ms8_r, mc8_r, ms9_r, mc9_r;
  logic [29:0] sr11_r, mc11_r;
  logic signed [16:0] sin_r, cos_r;

  logic [13:0] t_oct;
  logic [46:0] x_prod;
  logic [29:0] x1_nxt;
  logic [31:0] s_sum;
  logic [30:0] c_full;
  logic [31:0] c_sum;
  logic signed [16:0] s_oct, c_oct, s0, c0;
  logic signed [16:0] sin_nxt, cos_nxt;

  // Fold the quadrant's upper half onto the lower octant.
  always_comb begin
    t_oct  = angle[13] ? 14'(15'd16384 - {1'b0, angle[13:0]}) : angle[13:0];
    x_prod = 47'(t_oct) * TWO_PI_Q30 + 47'd32768;
    x1_nxt = x_prod[45:16];
  end

  always_comb begin
    s_sum  = 32'(sr11_r) + 32'd16384;
    c_full = Q30_ONE - {2'b00, mc11_r[29:1]};
    c_sum  = 32'(c_full) + 32'd16384;
    s_oct  = s_sum[31:15];
    c_oct  = c_sum[31:15];
    s0     = sw_r[11] ? c_oct : s_oct;
    c0     = sw_r[11] ? s_oct : c_oct;
    case (qd_r[11])
      2'd0: begin
        sin_nxt = s0;
        cos_nxt = c0;
      end
      2'd1: begin
        sin_nxt = c0;
        cos_nxt = -s0;
      end
      2'd2: begin
        sin_nxt = -s0;
        cos_nxt = -c0;
      end
      default: begin
        sin_nxt = -c0;
        cos_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[1]  <= x1_nxt;
      qd_r[1] <= angle[15:14];
      sw_r[1] <= angle[13];
      for (int k = 2; k <= 10; k++) begin
        x_r[k] <= x_r[k-1];
      end
      for (int k = 2; k <= 11; k++) begin
        qd_r[k] <= qd_r[k-1];
        sw_r[k] <= sw_r[k-1];
      end
      x2_r[2] <= mul30(x_r[1], {1'b0, x_r[1]});
      for (int k = 3; k <= 10; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      // First Horner step: divide by 42 and 56.
      prs3_r <= 64'(x2_r[2]) * R42;
      prc3_r <= 64'(x2_r[2]) * R56;
      ps4_r  <= Q30_ONE - {1'b0, div_fix(x2_r[3], prs3_r, 6'd42)};
      pc4_r  <= Q30_ONE - {1'b0, div_fix(x2_r[3], prc3_r, 6'd56)};
      ms5_r  <= mul30(x2_r[4], ps4_r);
      mc5_r  <= mul30(x2_r[4], pc4_r);
      // Second step: divide by 20 and 30.
      prs6_r <= 64'(ms5_r) * R20;
      prc6_r <= 64'(mc5_r) * R30;
      ms6_r  <= ms5_r;
      mc6_r  <= mc5_r;
      ps7_r  <= Q30_ONE - {1'b0, div_fix(ms6_r, prs6_r, 6'd20)};
      pc7_r  <= Q30_ONE - {1'b0, div_fix(mc6_r, prc6_r, 6'd30)};
      ms8_r  <= mul30(x2_r[7], ps7_r);
      mc8_r  <= mul30(x2_r[7], pc7_r);
      // Third step: divide by 6 and 12.
      prs9_r <= 64'(ms8_r) * R6;
      prc9_r <= 64'(mc8_r) * R12;
      ms9_r  <= ms8_r;
      mc9_r  <= mc8_r;
      ps10_r <= Q30_ONE - {1'b0, div_fix(ms9_r, prs9_r, 6'd6)};
      pc10_r <= Q30_ONE - {1'b0, div_fix(mc9_r, prc9_r, 6'd12)};
      sr11_r <= mul30(x_r[10], ps10_r);
      mc11_r <= mul30(x2_r[10], pc10_r);
      sin_r  <= sin_nxt;
      cos_r  <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ----- rtl/euler_trs_model_matrix.sv -----
// Translate-scale-rotate model matrix with Euler XYZ rotation, fixed point.
// Throughput is one item per cycle while the output is not stalled, set by a
// fully pipelined sine/cosine unit per axis.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears every valid bit; data needs none.
module euler_trs_model_matrix (
  input  logic      clk,
  input  logic      rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch
);
  import trs_pkg::*;

  // Stages 1..12 are the sine/cosine units, 13..15 build the rotation
  // matrix, and stage 16 is the output register.
  localparam int unsigned MatStage = 15;

  logic en;
  logic vld_r [1:MatStage];
  logic out_valid_r;
  in_item_t  dly_r [1:MatStage];
  out_item_t out_r;

  logic signed [16:0] sx, cx, sy, cy, sz, cz;

  // Stage 13 products.
  logic signed [16:0] cycz_r, cysz_r, cxsz_r, cxcz_r, sxcy_r, cxcy_r;
  logic signed [16:0] sxsz_r, sxcz_r, sxsy_r, cxsy_r, sy_r, cz_r, sz_r;
  // Stage 14 triple products and passed-through terms.
  logic signed [16:0] r0_r, r1_r, r2_r, r5_r, r8_r;
  logic signed [16:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [16:0] cxsz2_r, cxcz2_r, sxsz2_r, sxcz2_r;
  // Stage 15 rotation matrix.
  logic signed [16:0] rot_r [0:8];

  out_item_t out_nxt;

  // The pipeline moves whenever the output register is free or drained.
  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  trs_sincos u_sc_x (.clk(clk), .en(en), .angle(in_ch.data.angle_x), .sin_o(sx), .cos_o(cx));
  trs_sincos u_sc_y (.clk(clk), .en(en), .angle(in_ch.data.angle_y), .sin_o(sy), .cos_o(cy));
  trs_sincos u_sc_z (.clk(clk), .en(en), .angle(in_ch.data.angle_z), .sin_o(sz), .cos_o(cz));

  // Valid bits travel alongside the data and are the only reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= MatStage; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_ch.valid;
      for (int k = 2; k <= MatStage; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[MatStage];
    end
  end

  // Final scaling: row i of the rotation is scaled by scale i, and the
  // translation column is the delayed position.
  always_comb begin
    out_nxt.m00     = scale_out(rot_r[0], dly_r[MatStage].scale_x);
    out_nxt.m01     = scale_out(rot_r[1], dly_r[MatStage].scale_x);
    out_nxt.m02     = scale_out(rot_r[2], dly_r[MatStage].scale_x);
    out_nxt.m10     = scale_out(rot_r[3], dly_r[MatStage].scale_y);
    out_nxt.m11     = scale_out(rot_r[4], dly_r[MatStage].scale_y);
    out_nxt.m12     = scale_out(rot_r[5], dly_r[MatStage].scale_y);
    out_nxt.m20     = scale_out(rot_r[6], dly_r[MatStage].scale_z);
    out_nxt.m21     = scale_out(rot_r[7], dly_r[MatStage].scale_z);
    out_nxt.m22     = scale_out(rot_r[8], dly_r[MatStage].scale_z);
    out_nxt.trans_x = dly_r[MatStage].pos_x;
    out_nxt.trans_y = dly_r[MatStage].pos_y;
    out_nxt.trans_z = dly_r[MatStage].pos_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[1] <= in_ch.data;
      for (int k = 2; k <= MatStage; k++) begin
        dly_r[k] <= dly_r[k-1];
      end

      // Pairwise products of the six sines and cosines.
      cycz_r <= fmul(cy, cz);
      cysz_r <= fmul(cy, sz);
      cxsz_r <= fmul(cx, sz);
      cxcz_r <= fmul(cx, cz);
      sxcy_r <= fmul(sx, cy);
      cxcy_r <= fmul(cx, cy);
      sxsz_r <= fmul(sx, sz);
      sxcz_r <= fmul(sx, cz);
      sxsy_r <= fmul(sx, sy);
      cxsy_r <= fmul(cx, sy);
      sy_r   <= sy;
      cz_r   <= cz;
      sz_r   <= sz;

      // Triple products, built from the registered pair with sin y.
      r0_r    <= cycz_r;
      r1_r    <= -cysz_r;
      r2_r    <= sy_r;
      r5_r    <= -sxcy_r;
      r8_r    <= cxcy_r;
      t1_r    <= fmul(sxsy_r, cz_r);
      t2_r    <= fmul(sxsy_r, sz_r);
      t3_r    <= fmul(cxsy_r, cz_r);
      t4_r    <= fmul(cxsy_r, sz_r);
      cxsz2_r <= cxsz_r;
      cxcz2_r <= cxcz_r;
      sxsz2_r <= sxsz_r;
      sxcz2_r <= sxcz_r;

      // Entries that are sums are saturated to plus or minus one.
      rot_r[0] <= r0_r;
      rot_r[1] <= r1_r;
      rot_r[2] <= r2_r;
      rot_r[3] <= clamp1(18'(cxsz2_r) + 18'(t1_r));
      rot_r[4] <= clamp1(18'(cxcz2_r) - 18'(t2_r));
      rot_r[5] <= r5_r;
      rot_r[6] <= clamp1(18'(sxsz2_r) - 18'(t3_r));
      rot_r[7] <= clamp1(18'(sxcz2_r) + 18'(t4_r));
      rot_r[8] <= r8_r;

      out_r <= out_nxt;
    end
  end

endmodule

// ----- test/tb.sv -----
// Self-checking bench for euler_trs_model_matrix: directed table, then random transforms.
// Depends on trs_pkg, trs_in_if, trs_out_if and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 1400;
  localparam int CycleLimit = 400000;
  localparam int LongHold   = 400;
  localparam int DrainWait  = 40;
  localparam int QuietFirst = 1000;
  localparam int QuietLast  = 1150;
  localparam int HoldAt     = 300;
  localparam int PauseAt    = 700;

  logic clk = 1'b0;
  logic rst_n;

  trs_in_if  in_ch ();
  trs_out_if out_ch ();

  euler_trs_model_matrix u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // One row of the directed table. Rows flagged as typed carry an expected
  // matrix written out by hand; every other row goes through the predictor.
  typedef struct {
    trs_pkg::in_item_t  stim;
    bit                 typed;
    trs_pkg::out_item_t want;
  } row_t;

  trs_pkg::out_item_t matrix_q[$];
  int                 err_cnt = 0;
  int                 sent_cnt = 0;
  int                 got_cnt = 0;
  int                 cycle_cnt = 0;
  row_t               rows[$];

  // ---------------------------------------------------------------------
  // Predictor: fixed-point sine/cosine, Q1.15 products and Q16.16 scaling.
  // ---------------------------------------------------------------------

  // floor((v + 2^(sh-1)) / 2^sh) on signed 64-bit values.
  function automatic longint round_shr(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint q15_mul(input longint a, input longint b);
    return round_shr(a * b, 15);
  endfunction

  function automatic longint sat_unit(input longint v);
    if (v > 32768) begin
      return 32768;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Sine and cosine of t/65536 turn for t in 0..8192, via truncated Taylor
  // series in unsigned Q2.30 radians.
  function automatic void octant_sin_cos(input longint unsigned t,
                                         output longint s, output longint c);
    longint unsigned one, x, x2, p;
    one = 64'd1 << 30;
    x   = (t * 64'd6746518852 + 64'd32768) >> 16;
    x2  = q30_mul(x, x);
    p = one - x2 / 42;
    p = one - q30_mul(x2, p) / 20;
    p = one - q30_mul(x2, p) / 6;
    p = q30_mul(x, p);
    s = longint'((p + 64'd16384) >> 15);
    p = one - x2 / 56;
    p = one - q30_mul(x2, p) / 30;
    p = one - q30_mul(x2, p) / 12;
    p = one - q30_mul(x2, p) / 2;
    c = longint'((p + 64'd16384) >> 15);
  endfunction

  function automatic void angle_sin_cos(input logic [15:0] ang,
                                        output longint s, output longint c);
    longint s0, c0;
    logic [13:0] r;
    r = ang[13:0];
    if (r < 14'd8192) begin
      octant_sin_cos(r, s0, c0);
    end else begin
      octant_sin_cos(16384 - r, c0, s0);
    end
    case (ang[15:14])
      2'd0: begin s = s0;  c = c0;  end
      2'd1: begin s = c0;  c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic trs_pkg::out_item_t model_matrix(input trs_pkg::in_item_t d);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint rot[9];
    longint scl[3];
    logic [31:0] m[9];
    trs_pkg::out_item_t res;
    angle_sin_cos(d.angle_x, sx, cx);
    angle_sin_cos(d.angle_y, sy, cy);
    angle_sin_cos(d.angle_z, sz, cz);
    scl[0] = d.scale_x;
    scl[1] = d.scale_y;
    scl[2] = d.scale_z;
    sxsy = q15_mul(sx, sy);
    cxsy = q15_mul(cx, sy);
    rot[0] = q15_mul(cy, cz);
    rot[1] = -q15_mul(cy, sz);
    rot[2] = sy;
    rot[3] = sat_unit(q15_mul(cx, sz) + q15_mul(sxsy, cz));
    rot[4] = sat_unit(q15_mul(cx, cz) - q15_mul(sxsy, sz));
    rot[5] = -q15_mul(sx, cy);
    rot[6] = sat_unit(q15_mul(sx, sz) - q15_mul(cxsy, cz));
    rot[7] = sat_unit(q15_mul(sx, cz) + q15_mul(cxsy, sz));
    rot[8] = q15_mul(cx, cy);
    for (int i = 0; i < 9; i++) begin
      m[i] = 32'(round_shr(rot[i] * scl[i / 3], 7));
    end
    res = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
            d.pos_x, d.pos_y, d.pos_z};
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Random field generators, biased toward extremes and octant boundaries.
  // ---------------------------------------------------------------------
  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0100;
      3: return 16'hff00;
      4: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
      1: return 16'($urandom_range(0, 3) * 16384);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic trs_pkg::in_item_t random_transform();
    trs_pkg::in_item_t d;
    d.pos_x   = pick_pos();
    d.pos_y   = pick_pos();
    d.pos_z   = pick_pos();
    d.scale_x = pick_scale();
    d.scale_y = pick_scale();
    d.scale_z = pick_scale();
    d.angle_x = pick_angle();
    d.angle_y = pick_angle();
    d.angle_z = pick_angle();
    return d;
  endfunction

  function automatic row_t make_row(input logic [31:0] px, py, pz,
                                    input logic [15:0] kx, ky, kz,
                                    input logic [15:0] ax, ay, az);
    row_t r;
    r.stim  = '{px, py, pz, kx, ky, kz, ax, ay, az};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // Directed table. The first two rows are checked against hand values:
  // zero angles with unit scale give the identity, zero scale gives zeros.
  initial begin
    row_t r;
    r = make_row(32'h0001_0000, 32'hffff_0000, 32'h1234_5678,
                 16'h0100, 16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0);
    r.typed = 1'b1;
    r.want  = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000,
                32'h0001_0000, 32'hffff_0000, 32'h1234_5678};
    rows.push_back(r);
    r = make_row(32'h8000_0000, 32'h7fff_ffff, 32'h0,
                 16'h0, 16'h0, 16'h0, 16'h1357, 16'h9abc, 16'hfedc);
    r.typed = 1'b1;
    r.want  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h0};
    rows.push_back(r);
    // Scale extremes, including the most negative code.
    rows.push_back(make_row(32'hffff_ffff, 32'h0, 32'h8000_0000,
                            16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0));
    rows.push_back(make_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            16'h7fff, 16'h7fff, 16'h7fff, 16'h0, 16'h0, 16'h0));
    // Quadrant starts and octant edges on every axis.
    rows.push_back(make_row(0, 0, 0, 16'h0100, 16'h0100, 16'h0100,
                            16'h4000, 16'h4000, 16'h4000));
    rows.push_back(make_row(0, 0, 0, 16'h0100, 16'h0100, 16'h0100,
                            16'h8000, 16'h8000, 16'h8000));
    rows.push_back(make_row(0, 0, 0, 16'h0100, 16'h0100, 16'h0100,
                            16'hc000, 16'hc000, 16'hc000));
    rows.push_back(make_row(0, 0, 0, 16'h0100, 16'h0100, 16'h0100,
                            16'h2000, 16'h2000, 16'h2000));
    rows.push_back(make_row(0, 0, 0, 16'h0100, 16'h0100, 16'h0100,
                            16'h1fff, 16'h3fff, 16'hffff));
    rows.push_back(make_row(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff,
                            16'h6000, 16'ha000, 16'he000));
    // Sums that may round past one and saturate.
    rows.push_back(make_row(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff,
                            16'h2000, 16'h2000, 16'h6000));
    rows.push_back(make_row(0, 0, 0, 16'h8000, 16'h8000, 16'h8000,
                            16'h2001, 16'h5fff, 16'h9fff));
    // Negative scale and mixed content.
    rows.push_back(make_row(32'h0012_3456, 32'hfedc_ba98, 32'h0000_8000,
                            16'hff00, 16'hfe80, 16'h0001, 16'h1111, 16'h2222, 16'h3333));
    rows.push_back(make_row(32'hdead_beef, 32'h0bad_f00d, 32'h5555_aaaa,
                            16'haaaa, 16'h5555, 16'hffff, 16'haaaa, 16'h5555, 16'hffff));
  end

  // ---------------------------------------------------------------------
  // Input side. Each item may wait a random gap before it is offered, except in
  // a quiet stretch; at one point the sender drains the block completely.
  // ---------------------------------------------------------------------
  task automatic send_transform(input trs_pkg::in_item_t d, input trs_pkg::out_item_t want);
    int gap;
    gap = (sent_cnt >= QuietFirst && sent_cnt < QuietLast) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= d;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    matrix_q.push_back(want);
    sent_cnt++;
  endtask

  initial begin
    trs_pkg::in_item_t d;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    out_ch.ready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_transform(rows[i].stim, rows[i].typed ? rows[i].want : model_matrix(rows[i].stim));
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == PauseAt) begin
        // Let every outstanding matrix come back before going on.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (matrix_q.size() == 0);
        @(posedge clk);
      end
      d = random_transform();
      send_transform(d, model_matrix(d));
    end
    in_ch.valid <= 1'b0;

    wait (matrix_q.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side. Ready may be dropped for a random gap ahead of each transfer;
  // once it is held low for a long stretch so the pipeline fills and stalls.
  // ---------------------------------------------------------------------
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (got_cnt == HoldAt) begin
        hold = LongHold;
      end else if (got_cnt >= QuietFirst && got_cnt < QuietLast) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got_cnt++;
    end
  end

  // Every result transfer is compared field by field with the oldest
  // pending matrix.
  always @(posedge clk) begin
    trs_pkg::out_item_t want;
    logic [11:0][31:0] w_fld, g_fld;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, out_ch.data);
        err_cnt++;
      end else begin
        want  = matrix_q.pop_front();
        w_fld = want;
        g_fld = out_ch.data;
        for (int f = 0; f < 12; f++) begin
          if (w_fld[11 - f] !== g_fld[11 - f]) begin
            $display("%0t: field %0d (m00..m22, trans_x..z) expected %h actual %h",
                     $time, f, w_fld[11 - f], g_fld[11 - f]);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
